[sv/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising aclk edge outside reset
`define KLED_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked on every rising aclk edge, reset included
`define KLED_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[sv/kled_pkg.sv]
`default_nettype none

package kled_pkg;

    // key table depth and its address width
    localparam int NUM_KEYS = 128;
    localparam int KEY_AW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // field widths
    localparam int KEY_W    = 7;
    localparam int TIME_W   = 32;
    localparam int COLOR_W  = 24;
    localparam int FADE_W   = 16;
    localparam int LED_W    = 8;
    localparam int CHAN_W   = 8;
    localparam int PROD_W   = 40;

    // stream payload widths
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_COLOUR = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FADE_MS     = 1'b1;

    localparam logic [COLOR_W-1:0] PRESSED_RESET = 24'h660066;
    localparam logic [FADE_W-1:0]  FADE_RESET    = 16'd150;
    localparam logic [COLOR_W-1:0] BLACK         = 24'h000000;

    // one entry of the per-key table
    typedef struct packed {
        logic              was_on;
        logic              fading;
        logic [TIME_W-1:0] start;
    } kled_entry_t;

endpackage

`default_nettype wire

[sv/key_led_fade_engine.sv]
// channel   | dir | tdata fields, lowest bit first                        | width
// s_ (in)   | in  | key_index[6:0] key_on[7] now_ms[39:8]                 | 40
// m_ (out)  | out | out_key[6:0] led_first[14:7] led_color[38:15]         | 40
//           |     | led_write[39]                                         |
// cfg_      | in  | index 0 held-key colour, index 1 fade_ms              | 24
//
// one item at a time: a press, a black write or an idle key goes from accept
// through the table read and decision to the output register; an item that
// lands inside a fade, a release included, also passes the squares, the scaled
// products, then 8 restoring-division steps shared by the three colour channels
// aresetn is synchronous; it clears the key table valid bits, so every key
// starts off and not fading, and no clearing pass is needed
// a stalled result waits in the output register; the next item is taken
// meanwhile and only waits when its own result is ready
`default_nettype none

module key_led_fade_engine import kled_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // key_index[6:0], key_on[7], now_ms[39:8]
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    // out_key[6:0], led_first[14:7], led_color[38:15], led_write[39]
    output      logic [M_DATA_W-1:0]   m_tdata,
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0; // waiting for an item
    localparam logic [2:0] ST_LOOK = 3'd1; // table entry is back, decide and write back
    localparam logic [2:0] ST_SQ   = 3'd2; // squares of fade time and elapsed time
    localparam logic [2:0] ST_MUL  = 3'd3; // channel times remaining fraction numerator
    localparam logic [2:0] ST_DIV  = 3'd4; // one quotient bit per cycle
    localparam logic [2:0] ST_DONE = 3'd5; // hand result to the output register

    localparam logic [8:0] KEY_LIMIT = 9'(NUM_KEYS);

    // configuration
    logic [COLOR_W-1:0] hold_colour_reg, hold_colour_next;
    logic [FADE_W-1:0]  fade_ms_reg, fade_ms_next;

    // control
    logic [2:0]          state_reg, state_next;
    logic [NUM_KEYS-1:0] valid_reg, valid_next;
    logic                m_valid_reg, m_valid_next;
    logic [2:0]          cnt_reg, cnt_next;

    // item payload
    logic [KEY_W-1:0]    key_reg, key_next;
    logic                on_reg, on_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [COLOR_W-1:0]  res_color_reg, res_color_next;
    logic                res_write_reg, res_write_next;
    logic [FADE_W-1:0]   elapsed_reg, elapsed_next;
    logic [TIME_W-1:0]   tt_reg, tt_next;
    logic [TIME_W-1:0]   ee_reg, ee_next;
    logic [2:0][PROD_W-1:0]   prod_reg, prod_next;
    logic [PROD_W-1:0]        dsh_reg, dsh_next;
    logic [2:0][CHAN_W-1:0]   quo_reg, quo_next;
    logic [M_DATA_W-1:0]      m_data_reg, m_data_next;

    // key table
    kled_entry_t state_mem [NUM_KEYS];
    kled_entry_t mem_q_reg;
    logic        mem_we;
    kled_entry_t mem_wdata;
    logic        rd_en;

    logic [8:0]        key_ext;
    logic [KEY_AW-1:0] key_addr;
    logic [8:0]        in_key_ext;
    logic [KEY_AW-1:0] rd_addr;
    logic              key_ok;

    // lookup decision
    logic              was_on, was_fading, fad_n;
    logic [TIME_W-1:0] start_n;
    logic [TIME_W-1:0] elapsed;
    logic              fade_go;
    logic [COLOR_W-1:0] look_color;
    logic              look_write;

    logic [TIME_W-1:0] num;
    logic              out_free;
    logic [2:0]        qbit;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign rd_en    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign in_key_ext = {2'b00, s_tdata[KEY_W-1:0]};
    assign rd_addr    = in_key_ext[KEY_AW-1:0];
    assign key_ext    = {2'b00, key_reg};
    assign key_addr   = key_ext[KEY_AW-1:0];
    assign key_ok     = (key_ext < KEY_LIMIT);

    // table: one write port, one registered read port; the write of an item
    // always lands before the next item's read is issued
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            state_mem[key_addr] <= mem_wdata;
        end
        if (rd_en) begin
            mem_q_reg <= state_mem[rd_addr];
        end
    end

    // per-key decision on the entry just read
    always_comb begin
        was_on     = valid_reg[key_addr] & mem_q_reg.was_on;
        was_fading = valid_reg[key_addr] & mem_q_reg.fading;
        fad_n      = was_fading;
        start_n    = mem_q_reg.start;
        look_color = BLACK;
        look_write = 1'b0;
        fade_go    = 1'b0;
        if (on_reg && !was_on) begin
            // press: full colour, any fade stops
            look_color = hold_colour_reg;
            look_write = 1'b1;
            fad_n      = 1'b0;
        end else if (!on_reg && was_on) begin
            // release: fade starts now
            fad_n   = 1'b1;
            start_n = now_reg;
        end
        elapsed = now_reg - start_n;
        if (!on_reg && fad_n) begin
            look_write = 1'b1;
            if (elapsed >= {16'd0, fade_ms_reg}) begin
                // fade over (also covers a zero fade time)
                look_color = BLACK;
                fad_n      = 1'b0;
            end else begin
                fade_go = 1'b1;
            end
        end
        if (!key_ok) begin
            look_color = BLACK;
            look_write = 1'b0;
            fade_go    = 1'b0;
        end
        mem_wdata.was_on = on_reg;
        mem_wdata.fading = fad_n;
        mem_wdata.start  = start_n;
        mem_we = (state_reg == ST_LOOK) && key_ok;
    end

    assign num = tt_reg - ee_reg;

    // restoring division, all three channels against the same shifted divisor
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qbit[i] = (prod_reg[i] >= dsh_reg);
        end
    end

    always_comb begin
        hold_colour_next   = hold_colour_reg;
        fade_ms_next       = fade_ms_reg;
        state_next         = state_reg;
        valid_next         = valid_reg;
        m_valid_next       = m_valid_reg;
        cnt_next           = cnt_reg;
        key_next           = key_reg;
        on_next            = on_reg;
        now_next           = now_reg;
        res_color_next     = res_color_reg;
        res_write_next     = res_write_reg;
        elapsed_next       = elapsed_reg;
        tt_next            = tt_reg;
        ee_next            = ee_reg;
        prod_next          = prod_reg;
        dsh_next           = dsh_reg;
        quo_next           = quo_reg;
        m_data_next        = m_data_reg;

        if (cfg_wen) begin
            case (cfg_addr)
                CFG_HOLD_COLOUR: hold_colour_next = cfg_wdata[COLOR_W-1:0];
                CFG_FADE_MS:     fade_ms_next     = cfg_wdata[FADE_W-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (rd_en) begin
                    key_next   = s_tdata[KEY_W-1:0];
                    on_next    = s_tdata[KEY_W];
                    now_next   = s_tdata[KEY_W+1 +: TIME_W];
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (key_ok) begin
                    valid_next[key_addr] = 1'b1;
                end
                res_color_next = look_color;
                res_write_next = look_write;
                elapsed_next   = elapsed[FADE_W-1:0];
                state_next     = fade_go ? ST_SQ : ST_DONE;
            end
            ST_SQ: begin
                tt_next    = TIME_W'(fade_ms_reg) * TIME_W'(fade_ms_reg);
                ee_next    = TIME_W'(elapsed_reg) * TIME_W'(elapsed_reg);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                for (int i = 0; i < 3; i++) begin
                    prod_next[i] = PROD_W'(hold_colour_reg[CHAN_W*i +: CHAN_W])
                                 * PROD_W'(num);
                end
                // quotient never exceeds the channel, so start at bit 7
                dsh_next   = {1'b0, tt_reg, 7'd0};
                cnt_next   = 3'd7;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    if (qbit[i]) begin
                        prod_next[i] = prod_reg[i] - dsh_reg;
                    end
                    quo_next[i] = {quo_reg[i][CHAN_W-2:0], qbit[i]};
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0) begin
                    res_color_next = {quo_next[2], quo_next[1], quo_next[0]};
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_next  = {res_write_reg, res_color_reg, key_reg, 1'b0, key_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_colour_reg   <= PRESSED_RESET;
            fade_ms_reg       <= FADE_RESET;
            state_reg         <= ST_IDLE;
            valid_reg         <= '0;
            m_valid_reg       <= 1'b0;
            cnt_reg           <= 3'd0;
        end else begin
            hold_colour_reg   <= hold_colour_next;
            fade_ms_reg       <= fade_ms_next;
            state_reg         <= state_next;
            valid_reg         <= valid_next;
            m_valid_reg       <= m_valid_next;
            cnt_reg           <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        on_reg        <= on_next;
        now_reg       <= now_next;
        res_color_reg <= res_color_next;
        res_write_reg <= res_write_next;
        elapsed_reg   <= elapsed_next;
        tt_reg        <= tt_next;
        ee_reg        <= ee_next;
        prod_reg      <= prod_next;
        dsh_reg       <= dsh_next;
        quo_reg       <= quo_next;
        m_data_reg    <= m_data_next;
    end

endmodule

`default_nettype wire

[sv/kled_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module kled_checker import kled_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [M_DATA_W-1:0]   m_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready
);

    logic               out_stall;
    logic               out_write;
    logic [COLOR_W-1:0] out_colour;

    assign out_stall  = m_tvalid && !m_tready;
    assign out_write  = m_tdata[M_DATA_W-1];
    assign out_colour = m_tdata[38:15];

    // a stalled result holds
    `KLED_ASSERT(a_out_hold, out_stall |=> m_tvalid && $stable(m_tdata), "stalled result moved")

    // one item at a time: no second accept straight after the first
    `KLED_ASSERT(a_one_item, s_tvalid && s_tready |=> !s_tready, "second item taken")

    // no result pending right after reset
    `KLED_ASSERT_NR(a_reset_empty, $past(!aresetn) |-> !m_tvalid, "result after reset")

    // a result without a write carries black
    `KLED_ASSERT(a_idle_black, m_tvalid && !out_write |-> out_colour == BLACK, "stray colour")

endmodule

bind key_led_fade_engine kled_checker u_kled_checker (.*);

`default_nettype wire

[tb/sv/tb_key_led_fade_engine.sv]
`default_nettype none

module tb_key_led_fade_engine;
    import kled_pkg::*;

    // run ends here if the block hangs
    localparam int unsigned RUN_LIMIT = 400000;
    // items per random chunk; three chunks per idling phase
    localparam int CHUNK_ITEMS = 150;

    // one result item, laid out exactly as m_tdata
    typedef struct packed {
        logic               wr;
        logic [COLOR_W-1:0] colour;
        logic [LED_W-1:0]   led;
        logic [KEY_W-1:0]   key;
    } led_result_t;

    // directed rows: a key item, or a register write whose value sits in colour
    typedef enum logic [1:0] {ROW_ITEM, ROW_COLOUR, ROW_FADE} row_kind_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [KEY_W-1:0]   key;
        logic               on;
        logic [TIME_W-1:0]  now;
        logic               known;   // expected colour and write typed in below
        logic [COLOR_W-1:0] colour;
        logic               wr;
    } dir_row_t;

    localparam int DIR_ROWS = 33;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // first press after reset shows the reset colour
        '{ROW_ITEM,   7'd0,   1'b1, 32'd0,         1'b1, 24'h660066, 1'b1},
        // held key, nothing written
        '{ROW_ITEM,   7'd0,   1'b1, 32'd10,        1'b1, 24'h000000, 1'b0},
        // release: no time elapsed yet, full colour
        '{ROW_ITEM,   7'd0,   1'b0, 32'd100,       1'b1, 24'h660066, 1'b1},
        '{ROW_ITEM,   7'd0,   1'b0, 32'd175,       1'b0, 24'h000000, 1'b0},
        '{ROW_ITEM,   7'd0,   1'b0, 32'd249,       1'b0, 24'h000000, 1'b0},
        // elapsed reaches the fade length: black, fade over
        '{ROW_ITEM,   7'd0,   1'b0, 32'd250,       1'b1, 24'h000000, 1'b1},
        '{ROW_ITEM,   7'd0,   1'b0, 32'd260,       1'b1, 24'h000000, 1'b0},
        // top key, fade across the time wrap
        '{ROW_ITEM,   7'd127, 1'b1, 32'hFFFF_FFF0, 1'b1, 24'h660066, 1'b1},
        '{ROW_ITEM,   7'd127, 1'b0, 32'hFFFF_FFF0, 1'b1, 24'h660066, 1'b1},
        '{ROW_ITEM,   7'd127, 1'b0, 32'h0000_0020, 1'b0, 24'h000000, 1'b0},
        '{ROW_ITEM,   7'd127, 1'b0, 32'h0000_0086, 1'b1, 24'h000000, 1'b1},
        // key never pressed: its start time is never looked at
        '{ROW_ITEM,   7'd85,  1'b0, 32'd0,         1'b1, 24'h000000, 1'b0},
        '{ROW_ITEM,   7'd42,  1'b1, 32'd1,         1'b1, 24'h660066, 1'b1},
        '{ROW_ITEM,   7'd42,  1'b0, 32'd2,         1'b1, 24'h660066, 1'b1},
        // press in the middle of a fade stops it
        '{ROW_ITEM,   7'd42,  1'b1, 32'd50,        1'b1, 24'h660066, 1'b1},
        '{ROW_ITEM,   7'd42,  1'b0, 32'd60,        1'b1, 24'h660066, 1'b1},
        '{ROW_ITEM,   7'd42,  1'b0, 32'd61,        1'b0, 24'h000000, 1'b0},
        // widest colour and longest fade
        '{ROW_COLOUR, 7'd0,   1'b0, 32'd0,         1'b0, 24'hFFFFFF, 1'b0},
        '{ROW_FADE,   7'd0,   1'b0, 32'd0,         1'b0, 24'd65535,  1'b0},
        '{ROW_ITEM,   7'd1,   1'b1, 32'd1000,      1'b1, 24'hFFFFFF, 1'b1},
        '{ROW_ITEM,   7'd1,   1'b0, 32'd1000,      1'b1, 24'hFFFFFF, 1'b1},
        '{ROW_ITEM,   7'd1,   1'b0, 32'd66534,     1'b0, 24'h000000, 1'b0},
        '{ROW_ITEM,   7'd1,   1'b0, 32'd66535,     1'b1, 24'h000000, 1'b1},
        // fade still running on key 42, now against the new settings
        '{ROW_ITEM,   7'd42,  1'b0, 32'h0000_8000, 1'b0, 24'h000000, 1'b0},
        // black colour and the shortest fade
        '{ROW_COLOUR, 7'd0,   1'b0, 32'd0,         1'b0, 24'h000000, 1'b0},
        '{ROW_FADE,   7'd0,   1'b0, 32'd0,         1'b0, 24'd1,      1'b0},
        '{ROW_ITEM,   7'd2,   1'b1, 32'd5,         1'b1, 24'h000000, 1'b1},
        '{ROW_ITEM,   7'd2,   1'b0, 32'd5,         1'b1, 24'h000000, 1'b1},
        '{ROW_ITEM,   7'd2,   1'b0, 32'd6,         1'b1, 24'h000000, 1'b1},
        // zero fade length: release goes straight to black
        '{ROW_FADE,   7'd0,   1'b0, 32'd0,         1'b0, 24'd0,      1'b0},
        '{ROW_COLOUR, 7'd0,   1'b0, 32'd0,         1'b0, 24'h5A3CC3, 1'b0},
        '{ROW_ITEM,   7'd3,   1'b1, 32'd7,         1'b1, 24'h5A3CC3, 1'b1},
        '{ROW_ITEM,   7'd3,   1'b0, 32'd8,         1'b1, 24'h000000, 1'b1}
    };

    // clock, reset and block inputs, all known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // idling odds in percent, per side
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;

    // predictor copy of the registers and the key table
    logic [COLOR_W-1:0] shown_colour;
    logic [FADE_W-1:0]  fade_len;
    logic               key_down   [NUM_KEYS];
    logic               key_fading [NUM_KEYS];
    logic [TIME_W-1:0]  fade_t0    [NUM_KEYS];

    led_result_t pending_leds [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    key_led_fade_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // faded colour: each channel scaled by (T*T - e*e) / (T*T), truncated
    function automatic logic [COLOR_W-1:0] fade_colour(input logic [TIME_W-1:0] e);
        longint unsigned span;
        longint unsigned rest;
        longint unsigned chan;
        logic [COLOR_W-1:0] c;
        span = 64'(fade_len) * 64'(fade_len);
        rest = span - 64'(e) * 64'(e);
        for (int ch = 0; ch < 3; ch++) begin
            chan = 64'(shown_colour[8*ch +: 8]);
            c[8*ch +: 8] = 8'((chan * rest) / span);
        end
        return c;
    endfunction

    // next LED write for one key sample, advancing the key table
    task automatic predict_led(input logic [KEY_W-1:0] k, input logic on,
                               input logic [TIME_W-1:0] now, output led_result_t r);
        logic [TIME_W-1:0] e;
        r.key    = k;
        r.led    = {k, 1'b0};
        r.colour = '0;
        r.wr     = 1'b0;
        if (on && !key_down[k]) begin
            // press: full colour, any fade dropped
            r.colour      = shown_colour;
            r.wr          = 1'b1;
            key_fading[k] = 1'b0;
        end else if (!on && key_down[k]) begin
            // release: fade starts now
            key_fading[k] = 1'b1;
            fade_t0[k]    = now;
        end
        if (!on && key_fading[k]) begin
            e = now - fade_t0[k];
            if (e >= fade_len) begin
                r.colour      = BLACK;
                key_fading[k] = 1'b0;
            end else begin
                r.colour = fade_colour(e);
            end
            r.wr = 1'b1;
        end
        key_down[k] = on;
    endtask

    // present one item, hold it until taken, then queue what it should write;
    // called at a rising edge and returns at the edge that took the item
    task automatic send_item(input logic [KEY_W-1:0] k, input logic on,
                             input logic [TIME_W-1:0] now, input logic known,
                             input logic [COLOR_W-1:0] colour, input logic wr);
        led_result_t r;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, on, k};
        do @(posedge aclk); while (!s_tready);
        predict_led(k, on, now, r);
        if (known) begin
            r.colour = colour;
            r.wr     = wr;
        end
        pending_leds.push_back(r);
    endtask

    // drop valid, wait for every queued result, then cover the longest latency
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_leds.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // one register write, block idle; leaves the write enable low
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_HOLD_COLOUR: shown_colour = val[COLOR_W-1:0];
            CFG_FADE_MS:     fade_len     = val[FADE_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // receiver: stalls at random at the current odds
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // every result taken is held against the oldest expectation
    always @(posedge aclk) begin : check_results
        led_result_t got;
        led_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = led_result_t'(m_tdata);
            if (pending_leds.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: key %0d led %0d colour %06h write %0d",
                             got.key, got.led, got.colour, got.wr);
                end
            end else begin
                want = pending_leds.pop_front();
                if (got.key !== want.key || got.led !== want.led ||
                    got.colour !== want.colour || got.wr !== want.wr) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: want key %0d led %0d colour %06h write %0d",
                                 want.key, want.led, want.colour, want.wr);
                        $display("          got  key %0d led %0d colour %06h write %0d",
                                 got.key, got.led, got.colour, got.wr);
                    end
                end
            end
        end
    end

    // watchdog on the cycle count
    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        dir_row_t          row;
        logic [KEY_W-1:0]  k;
        logic              on;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] clock_ms;
        logic [KEY_W-1:0]  hot_key [4];
        logic              hot_on  [4];
        int unsigned       pick;
        int unsigned       hi;

        // predictor starts where reset leaves the block
        shown_colour = PRESSED_RESET;
        fade_len     = FADE_RESET;
        foreach (key_down[i]) begin
            key_down[i]   = 1'b0;
            key_fading[i] = 1'b0;
            fade_t0[i]    = '0;
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part: no idling at either side
        foreach (DIR_TABLE[i]) begin
            row = DIR_TABLE[i];
            case (row.kind)
                ROW_COLOUR: begin
                    settle();
                    write_reg(CFG_HOLD_COLOUR, row.colour);
                end
                ROW_FADE: begin
                    settle();
                    write_reg(CFG_FADE_MS, row.colour);
                end
                default: send_item(row.key, row.on, row.now, row.known, row.colour, row.wr);
            endcase
        end

        // random part: three idling phases, each in three chunks of settings
        clock_ms = $urandom();
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_gap_pct = 7;
                    recv_gap_pct = 57;
                end
                1: begin
                    send_gap_pct = 57;
                    recv_gap_pct = 7;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            for (int ch = 0; ch < 3; ch++) begin
                settle();
                // colour: extremes now and then, otherwise anything
                case ($urandom_range(0, 7))
                    0, 1:    write_reg(CFG_HOLD_COLOUR, 24'hFFFFFF);
                    2:       write_reg(CFG_HOLD_COLOUR, 24'h000000);
                    default: write_reg(CFG_HOLD_COLOUR, CFG_DATA_W'($urandom()));
                endcase
                // fade length: mostly short, with both ends of the range
                case ($urandom_range(0, 5))
                    0:       write_reg(CFG_FADE_MS, 24'd1);
                    1:       write_reg(CFG_FADE_MS, 24'd65535);
                    2, 3:    write_reg(CFG_FADE_MS, CFG_DATA_W'($urandom_range(2, 400)));
                    4:       write_reg(CFG_FADE_MS, CFG_DATA_W'($urandom_range(1, 5000)));
                    default: write_reg(CFG_FADE_MS, CFG_DATA_W'($urandom_range(1, 65535)));
                endcase
                // a few keys get whole press, hold, release, fade sequences
                foreach (hot_key[i]) begin
                    hot_key[i] = KEY_W'($urandom_range(0, NUM_KEYS - 1));
                    hot_on[i]  = 1'b0;
                end
                repeat (CHUNK_ITEMS) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 5) begin
                        // noise: any key at any time, often far back or ahead
                        k   = KEY_W'($urandom_range(0, NUM_KEYS - 1));
                        on  = 1'($urandom_range(0, 1));
                        now = $urandom();
                    end else begin
                        // time moves on in steps small against the fade
                        clock_ms = clock_ms + $urandom_range(0, fade_len / 16 + 2);
                        now      = clock_ms;
                        if (pick < 15) begin
                            k  = KEY_W'($urandom_range(0, NUM_KEYS - 1));
                            on = 1'($urandom_range(0, 1));
                        end else begin
                            hi = $urandom_range(0, 3);
                            if ($urandom_range(0, 99) < (hot_on[hi] ? 30 : 20)) begin
                                hot_on[hi] = !hot_on[hi];
                            end
                            k  = hot_key[hi];
                            on = hot_on[hi];
                        end
                    end
                    send_item(k, on, now, 1'b0, '0, 1'b0);
                end
            end
        end

        settle();
        if (mismatch_count == 0 && pending_leds.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
